### src/dzfb_pkg.sv
// Shared types, constants and the CRC byte step of the dimming-zone frame builder.
package dzfb_pkg;

   localparam int DAISY_LENGTH_DEF     = 4;
   localparam int CHANNEL_COUNT_DEF    = 4;
   localparam int ZONES_PER_DRIVER_DEF = 4;
   localparam int SLOTS_PER_DRIVER_DEF = 12;

   localparam int LEVEL_W      = 16;
   localparam int ZONE_IDX_W   = 6;
   localparam int WORD_IDX_W   = 8;
   localparam int ZONE_SPAN    = 2 ** ZONE_IDX_W;
   localparam int COLOUR_COUNT = 3;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_READ_DATA,
      ST_WRITE,
      ST_CRC_HDR,
      ST_CRC_PAY
   } state_type;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   typedef struct packed {
      logic                  action;
      logic [ZONE_IDX_W-1:0] zone_index;
      logic [LEVEL_W-1:0]    red_level;
      logic [LEVEL_W-1:0]    green_level;
      logic [LEVEL_W-1:0]    blue_level;
      logic [WORD_IDX_W-1:0] word_index;
   } req_item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] read_data;
      logic [LEVEL_W-1:0] crc_value;
      logic               frame_done;
      logic               range_error;
   } rsp_item_type;

   // One byte of CRC-16/CCITT-FALSE, most significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### src/dimming_zone_frame_builder_unit.sv
// Top level of the dimming-zone frame builder: frame store, zone mapping and CRC walk.
// A zone write stores one colour per cycle through the single write port before its result
// strobe; a read returns its word through the registered memory read, and a zone outside
// the map is answered with a range error. Writing the last zone adds the CRC walk, one
// byte per cycle. A new command is taken in the cycle its predecessor's result is strobed.
// Reset is synchronous; afterwards busy stays high while the frame store is swept to zero.
// The receiver cannot stall.
module dimming_zone_frame_builder_unit #(
   parameter int DAISY_LENGTH     = dzfb_pkg::DAISY_LENGTH_DEF,
   parameter int CHANNEL_COUNT    = dzfb_pkg::CHANNEL_COUNT_DEF,
   parameter int ZONES_PER_DRIVER = dzfb_pkg::ZONES_PER_DRIVER_DEF,
   parameter int SLOTS_PER_DRIVER = dzfb_pkg::SLOTS_PER_DRIVER_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dzfb_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   output dzfb_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data
);
   import dzfb_pkg::*;

   localparam int ZONES_PER_CHANNEL = DAISY_LENGTH * ZONES_PER_DRIVER;
   localparam int ZONE_COUNT        = ZONES_PER_CHANNEL * CHANNEL_COUNT;
   localparam int PAYLOAD_WORDS     = DAISY_LENGTH * SLOTS_PER_DRIVER * CHANNEL_COUNT;
   localparam int AW                = $clog2(PAYLOAD_WORDS);
   localparam int IW                = (AW + 2 > WORD_IDX_W) ? AW + 2 : WORD_IDX_W;

   // Zone map: a constant table over every code the zone field can carry. Each entry
   // says whether the zone is addressable, where its red word sits, and whether it is
   // the zone that closes the frame. Green and blue follow one channel stride apart.
   logic [ZONE_SPAN-1:0] zone_ok;
   logic [ZONE_SPAN-1:0] zone_last;
   logic [AW-1:0]        zone_base [ZONE_SPAN];

   for (genvar z = 0; z < ZONE_SPAN; z++) begin : g_zone
      localparam int DAISY = (z % ZONES_PER_CHANNEL) / ZONES_PER_DRIVER;
      localparam int CHAN  = z / ZONES_PER_CHANNEL;
      localparam int SLOT0 = (z % ZONES_PER_DRIVER) * COLOUR_COUNT;
      localparam bit OK    = (z < ZONE_COUNT) && (SLOT0 + COLOUR_COUNT <= SLOTS_PER_DRIVER);
      localparam int BASE  = OK ? (DAISY * SLOTS_PER_DRIVER + SLOT0) * CHANNEL_COUNT + CHAN : 0;
      assign zone_ok[z]   = OK;
      assign zone_last[z] = (z == ZONE_COUNT - 1);
      assign zone_base[z] = AW'(BASE);
   end

   // Control and datapath registers.
   state_type          state_ff, state_in;
   req_item_type       req_ff;
   logic               zone_ok_ff;
   logic               zone_last_ff;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic [1:0]         slot_cnt_ff, slot_cnt_in;
   logic [AW-1:0]      word_cnt_ff, word_cnt_in;
   logic               phase_ff, phase_in;
   logic [15:0]        crc_ff, crc_in;
   logic [15:0]        frame_crc_ff, frame_crc_in;
   logic [15:0]        header_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;

   // Frame store: one write port, one registered read port.
   logic [15:0]        frame_mem [PAYLOAD_WORDS];
   logic [15:0]        rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [15:0]        mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;

   logic               accept;
   logic [IW-1:0]      word_ext;
   logic [15:0]        colour_sel;
   logic [15:0]        crc_step;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign word_ext  = IW'(req_ff.word_index);

   always_comb begin
      case (slot_cnt_ff)
         2'd0:    colour_sel = req_ff.red_level;
         2'd1:    colour_sel = req_ff.green_level;
         default: colour_sel = req_ff.blue_level;
      endcase
   end

   // The CRC unit takes one byte per cycle. The header is fed from the register, the
   // payload words from the read port, high byte on the first phase and low byte on the
   // second.
   always_comb begin
      logic [7:0] crc_data;
      if (state_ff == ST_CRC_HDR) begin
         crc_data = phase_ff ? header_ff[7:0] : header_ff[15:8];
      end else begin
         crc_data = phase_ff ? rd_data_ff[7:0] : rd_data_ff[15:8];
      end
      crc_step = crc_byte(crc_ff, crc_data);
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (wr_addr_ff == AW'(PAYLOAD_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.action == ACT_READ) ? ST_READ : ST_WRITE;
            end
         end
         ST_READ: begin
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            state_in = ST_IDLE;
         end
         ST_WRITE: begin
            if (!zone_ok_ff) begin
               state_in = ST_IDLE;
            end else if (slot_cnt_ff == 2'd2) begin
               state_in = zone_last_ff ? ST_CRC_HDR : ST_IDLE;
            end
         end
         ST_CRC_HDR: begin
            if (phase_ff) begin
               state_in = ST_CRC_PAY;
            end
         end
         ST_CRC_PAY: begin
            if (phase_ff && word_cnt_ff == AW'(PAYLOAD_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output and datapath logic.
   always_comb begin
      wr_addr_in   = wr_addr_ff;
      slot_cnt_in  = slot_cnt_ff;
      word_cnt_in  = word_cnt_ff;
      phase_in     = phase_ff;
      crc_in       = crc_ff;
      frame_crc_in = frame_crc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_addr_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = word_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            wr_addr_in = wr_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               wr_addr_in  = zone_base[req_data.zone_index];
               slot_cnt_in = '0;
            end
         end
         ST_READ: begin
            mem_re    = (word_ext != '0) && (word_ext <= IW'(PAYLOAD_WORDS));
            mem_raddr = AW'(word_ext - IW'(1));
         end
         ST_READ_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            if (word_ext == '0) begin
               rsp_in.read_data = header_ff;
            end else if (word_ext <= IW'(PAYLOAD_WORDS)) begin
               rsp_in.read_data = rd_data_ff;
            end else if (word_ext == IW'(PAYLOAD_WORDS + 1)) begin
               rsp_in.read_data = frame_crc_ff;
            end else begin
               rsp_in.range_error = 1'b1;
            end
         end
         ST_WRITE: begin
            if (!zone_ok_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.range_error = 1'b1;
            end else begin
               mem_we      = 1'b1;
               mem_wdata   = colour_sel;
               wr_addr_in  = wr_addr_ff + AW'(CHANNEL_COUNT);
               slot_cnt_in = slot_cnt_ff + 2'd1;
               if (slot_cnt_ff == 2'd2) begin
                  if (zone_last_ff) begin
                     crc_in   = CRC_INIT;
                     phase_in = 1'b0;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
               end
            end
         end
         ST_CRC_HDR: begin
            crc_in   = crc_step;
            phase_in = !phase_ff;
            if (phase_ff) begin
               mem_re      = 1'b1;
               mem_raddr   = '0;
               word_cnt_in = '0;
            end
         end
         ST_CRC_PAY: begin
            crc_in   = crc_step;
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (word_cnt_ff == AW'(PAYLOAD_WORDS - 1)) begin
                  frame_crc_in      = crc_step;
                  rsp_valid_in      = 1'b1;
                  rsp_in            = '0;
                  rsp_in.crc_value  = crc_step;
                  rsp_in.frame_done = 1'b1;
               end else begin
                  word_cnt_in = word_cnt_ff + AW'(1);
                  mem_re      = 1'b1;
                  mem_raddr   = word_cnt_ff + AW'(1);
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Frame store.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[mem_raddr];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff       <= req_data;
         zone_ok_ff   <= zone_ok[req_data.zone_index];
         zone_last_ff <= zone_last[req_data.zone_index];
      end
      slot_cnt_ff <= slot_cnt_in;
      word_cnt_ff <= word_cnt_in;
      phase_ff    <= phase_in;
      crc_ff      <= crc_in;
      rsp_ff      <= rsp_in;
   end

   // Control registers; the write address doubles as the sweep counter after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wr_addr_ff   <= '0;
         frame_crc_ff <= '0;
         header_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_addr_ff   <= wr_addr_in;
         frame_crc_ff <= frame_crc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            header_ff <= csr_data;
         end
      end
   end

   // A result strobe always follows a cycle in which a command was being worked on.
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> $past(busy))
      else $error("result strobe without a command in progress");

   // A completed frame is never reported together with a range error.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_done) |-> !rsp_ff.range_error)
      else $error("frame completion flagged together with range error");

   // The frame store is never written while the block waits for a command.
   assert property (@(posedge clock) disable iff (reset) (state_ff == ST_IDLE) |-> !mem_we)
      else $error("frame store written while idle");

   // The CRC walk only starts from a write of an addressable, frame-closing zone.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRC_HDR && !phase_ff) |-> (zone_ok_ff && zone_last_ff))
      else $error("CRC walk started without the last zone");

endmodule
